>>> design/hrrq_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizes for the HID report request queue.
// No dependencies; every other file of the block except hrrq_desc_store imports this package.
package hrrq_pkg;

  // Queue geometry and report size limit.
  localparam int QUEUE_DEPTH      = 8;
  localparam int MAX_REPORT_BYTES = 64;
  localparam int IDX_W            = $clog2(QUEUE_DEPTH);
  localparam int CNT_W            = $clog2(QUEUE_DEPTH + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY  = 1'd1;
  localparam logic [15:0] SEND_TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] RETRY_DELAY_RESET  = 16'd50;

  // Command modes.
  localparam logic [2:0] MODE_QUEUE_OUT = 3'd0;
  localparam logic [2:0] MODE_QUEUE_SET = 3'd1;
  localparam logic [2:0] MODE_QUEUE_GET = 3'd2;
  localparam logic [2:0] MODE_POLL      = 3'd3;
  localparam logic [2:0] MODE_COMPLETE  = 3'd4;
  localparam logic [2:0] MODE_TICK      = 3'd5;

  // Result events.
  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_QUEUED     = 3'd1;
  localparam logic [2:0] EV_DROP_FULL  = 3'd2;
  localparam logic [2:0] EV_DROP_LONG  = 3'd3;
  localparam logic [2:0] EV_ISSUED     = 3'd4;
  localparam logic [2:0] EV_REFUSED    = 3'd5;
  localparam logic [2:0] EV_BACKOFF    = 3'd6;
  localparam logic [2:0] EV_COMPLETED  = 3'd7;

  // Request kinds.
  localparam logic [1:0] KIND_OUTPUT      = 2'd0;
  localparam logic [1:0] KIND_SET_FEATURE = 2'd1;
  localparam logic [1:0] KIND_GET_FEATURE = 2'd2;

  typedef struct packed {
    logic [2:0] mode;
    logic [6:0] usb_addr;
    logic [7:0] interface_num;
    logic [7:0] rpt_id;
    logic [7:0] length;
    logic       stack_accepts;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [2:0] slot;
    logic [6:0] out_usb_addr;
    logic [7:0] out_interface;
    logic [7:0] out_rpt_id;
    logic [7:0] out_length;
    logic [1:0] out_kind;
    logic       recovered;
    logic [3:0] queued_count;
    logic       ready_res;
  } rsp_item_t;

  typedef struct packed {
    logic [6:0] addr;
    logic [7:0] intf;
    logic [7:0] rid;
    logic [7:0] len;
    logic [1:0] kind;
  } desc_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    desc_t            data;
  } store_wr_t;

  typedef struct packed {
    logic tick;
    logic load_timeout;
    logic load_retry;
  } timer_ctl_t;

  typedef struct packed {
    logic timeout_zero;
    logic retry_zero;
  } timer_sts_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return idx + IDX_W'(1);
  endfunction

endpackage

>>> design/hrrq_intf.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command and result words.
// Depends on hrrq_pkg for the payload types.
interface hrrq_cmd_if import hrrq_pkg::*; ();
  logic      valid;
  logic      ready;
  cmd_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface hrrq_rsp_if import hrrq_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> design/hrrq_desc_store.sv
`timescale 1ns / 1ps
// Generic RAM with one write port and one registered read port.
// Self-contained; width and depth are set by the instantiating module.
module hrrq_desc_store #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/hrrq_timers.sv
`timescale 1ns / 1ps
// Configuration registers plus the send timeout and retry back-off counters.
// Depends on hrrq_pkg.
module hrrq_timers import hrrq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  timer_ctl_t            ctl,
  output timer_sts_t            sts
);

  logic [15:0] send_timeout;
  logic [15:0] retry_delay;
  logic [15:0] timeout_counter;
  logic [15:0] retry_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      send_timeout <= SEND_TIMEOUT_RESET;
      retry_delay  <= RETRY_DELAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEND_TIMEOUT: send_timeout <= cfg_wdata;
        CFG_RETRY_DELAY:  retry_delay  <= cfg_wdata;
      endcase
    end
  end

  // A tick never coincides with a load, since they come from different modes.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_counter <= '0;
      retry_counter   <= '0;
    end else begin
      if (ctl.load_timeout) begin
        timeout_counter <= send_timeout;
      end else if (ctl.tick && timeout_counter != '0) begin
        timeout_counter <= timeout_counter - 16'd1;
      end
      if (ctl.load_retry) begin
        retry_counter <= retry_delay;
      end else if (ctl.tick && retry_counter != '0) begin
        retry_counter <= retry_counter - 16'd1;
      end
    end
  end

  assign sts.timeout_zero = (timeout_counter == '0);
  assign sts.retry_zero   = (retry_counter == '0);

`ifndef SYNTHESIS
  a_timeout_load: assert property (@(posedge clk) disable iff (rst)
    ctl.load_timeout |=> timeout_counter == $past(send_timeout))
    else $error("timeout counter did not load");
  a_retry_tick: assert property (@(posedge clk) disable iff (rst)
    ctl.tick && !ctl.load_retry && retry_counter != '0
      |=> retry_counter == $past(retry_counter) - 16'd1)
    else $error("retry counter did not count down");
  a_no_load_clash: assert property (@(posedge clk) disable iff (rst)
    !(ctl.tick && (ctl.load_timeout || ctl.load_retry)))
    else $error("tick and load in the same cycle");
`endif

endmodule

>>> design/hrrq_core.sv
`timescale 1ns / 1ps
// Queue pointers, ready and back-off flags, and the per-word decision logic.
// Depends on hrrq_pkg; drives hrrq_desc_store and hrrq_timers.
module hrrq_core import hrrq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             proc,
  input  cmd_item_t        item,
  input  timer_sts_t       sts,
  input  desc_t            rd_desc,
  output logic [IDX_W-1:0] head_addr,
  output store_wr_t        wr,
  output timer_ctl_t       ctl,
  output rsp_item_t        res
);

  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] head_next;
  logic [IDX_W-1:0] tail;
  logic [IDX_W-1:0] tail_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             ready_flag;
  logic             ready_flag_next;
  logic             backoff_armed;
  logic             backoff_armed_next;
  logic             byp_valid;
  desc_t            byp_data;
  desc_t            head_desc;

  logic       is_set;
  logic [8:0] total;
  logic       too_long;
  logic       full;
  logic       recover;

  // The store read is registered, so a word written to the slot being read
  // in the same cycle is forwarded from the bypass register instead.
  assign head_desc = byp_valid ? byp_data : rd_desc;

  always_comb begin
    is_set   = (item.mode != MODE_QUEUE_GET);
    total    = {1'b0, item.length} +
               9'((is_set && item.rpt_id != '0) ? 1 : 0);
    too_long = (32'(total) > MAX_REPORT_BYTES) || total[8];
    full     = (count == CNT_W'(QUEUE_DEPTH));
    recover  = !ready_flag && sts.timeout_zero;

    head_next          = head;
    tail_next          = tail;
    count_next         = count;
    ready_flag_next    = ready_flag;
    backoff_armed_next = backoff_armed;
    wr                 = '0;
    ctl                = '0;
    res                = '0;

    unique case (item.mode)
      MODE_QUEUE_OUT, MODE_QUEUE_SET, MODE_QUEUE_GET: begin
        if (full) begin
          res.event_res = EV_DROP_FULL;
        end else if (is_set && too_long) begin
          res.event_res = EV_DROP_LONG;
        end else begin
          wr.en         = 1'b1;
          wr.addr       = tail;
          wr.data.addr  = item.usb_addr;
          wr.data.intf  = item.interface_num;
          wr.data.rid   = item.rpt_id;
          wr.data.len   = total[7:0];
          wr.data.kind  = item.mode[1:0];
          res.slot      = 3'(tail);
          tail_next     = next_idx(tail);
          count_next    = count + CNT_W'(1);
          res.event_res = EV_QUEUED;
        end
      end
      MODE_POLL: begin
        // A stuck transfer is recovered first; the same poll may then issue.
        if (recover) begin
          ready_flag_next = 1'b1;
          res.recovered   = 1'b1;
        end
        if (count != '0 && ready_flag_next) begin
          if (backoff_armed && !sts.retry_zero) begin
            res.event_res = EV_BACKOFF;
          end else begin
            backoff_armed_next = 1'b0;
            res.slot           = 3'(head);
            res.out_usb_addr   = head_desc.addr;
            res.out_interface  = head_desc.intf;
            res.out_rpt_id     = head_desc.rid;
            res.out_length     = head_desc.len;
            res.out_kind       = head_desc.kind;
            if (item.stack_accepts) begin
              ready_flag_next  = 1'b0;
              ctl.load_timeout = 1'b1;
              head_next        = next_idx(head);
              count_next       = count - CNT_W'(1);
              res.event_res    = EV_ISSUED;
            end else begin
              if (head_desc.kind != KIND_GET_FEATURE) begin
                backoff_armed_next = 1'b1;
                ctl.load_retry     = 1'b1;
              end
              res.event_res = EV_REFUSED;
            end
          end
        end
      end
      MODE_COMPLETE: begin
        ready_flag_next = 1'b1;
        res.event_res   = EV_COMPLETED;
      end
      MODE_TICK: begin
        ctl.tick = 1'b1;
      end
      default: begin
      end
    endcase

    res.queued_count = 4'(count_next);
    res.ready_res    = ready_flag_next;

    if (!proc) begin
      wr.en = 1'b0;
      ctl   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      tail          <= '0;
      count         <= '0;
      ready_flag    <= 1'b1;
      backoff_armed <= 1'b0;
      byp_valid     <= 1'b0;
    end else begin
      byp_valid <= wr.en && (wr.addr == head_addr);
      if (proc) begin
        head          <= head_next;
        tail          <= tail_next;
        count         <= count_next;
        ready_flag    <= ready_flag_next;
        backoff_armed <= backoff_armed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= wr.data;
  end

  // Read the slot that will be the head in the next cycle.
  assign head_addr = proc ? head_next : head;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");
  a_ring_pointers: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || full) |-> head == tail)
    else $error("head and tail disagree with entry count");
  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> !full)
    else $error("store written while queue full");
  a_issue_clears_ready: assert property (@(posedge clk) disable iff (rst)
    proc && res.event_res == EV_ISSUED |=> !ready_flag && count == $past(count) - CNT_W'(1))
    else $error("issue did not clear ready or pop the head");
`endif

endmodule

>>> design/hid_report_request_queue_top.sv
`timescale 1ns / 1ps
// HID report request queue: a ring of request descriptors dispatched one at a time.
// Depends on hrrq_pkg, hrrq_intf, hrrq_desc_store, hrrq_timers and hrrq_core.

// Every command word yields exactly one result word. The block takes one command
// per clock cycle while the result sink does not stall: the command is
// registered, the queue and timer state is updated by compare and pointer logic,
// and the result sits in an output register, so a new command can be held while
// an earlier result waits for the sink. Configuration writes to the timeout and
// back-off registers take effect on the next cycle and are meant to be issued
// while no command is in flight.
module hid_report_request_queue_top import hrrq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  hrrq_cmd_if.sink              cmd,
  hrrq_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic             ir_valid;
  cmd_item_t        ir_item;
  logic             or_valid;
  rsp_item_t        or_item;
  logic             proc;
  rsp_item_t        res;
  store_wr_t        wr;
  logic [IDX_W-1:0] head_addr;
  desc_t            rd_desc;
  timer_ctl_t       ctl;
  timer_sts_t       sts;

  assign proc      = ir_valid && (!or_valid || rsp.ready);
  assign cmd.ready = !ir_valid || proc;
  assign rsp.valid = or_valid;
  assign rsp.data  = or_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
      or_valid <= 1'b0;
    end else begin
      if (cmd.ready) begin
        ir_valid <= cmd.valid;
      end
      if (proc) begin
        or_valid <= 1'b1;
      end else if (rsp.ready) begin
        or_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      ir_item <= cmd.data;
    end
    if (proc) begin
      or_item <= res;
    end
  end

  hrrq_desc_store #(
    .WIDTH ($bits(desc_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (head_addr),
    .rdata (rd_desc)
  );

  hrrq_timers u_timers (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .sts       (sts)
  );

  hrrq_core u_core (
    .clk       (clk),
    .rst       (rst),
    .proc      (proc),
    .item      (ir_item),
    .sts       (sts),
    .rd_desc   (rd_desc),
    .head_addr (head_addr),
    .wr        (wr),
    .ctl       (ctl),
    .res       (res)
  );

`ifndef SYNTHESIS
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    or_valid && !rsp.ready |=> or_valid && $stable(or_item))
    else $error("waiting result word changed");
  a_cmd_held: assert property (@(posedge clk) disable iff (rst)
    ir_valid && !proc |=> ir_valid && $stable(ir_item))
    else $error("pending command word lost");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    proc |=> or_valid)
    else $error("processed command produced no result");
`endif

endmodule

>>> test/hid_report_request_queue_top_tb.sv
`timescale 1ns / 1ps
// Testbench for hid_report_request_queue_top: directed and random command words,
// each result predicted in the bench and checked field by field.
// Depends on hrrq_pkg, hrrq_intf and the block's design files.
module hid_report_request_queue_top_tb;
  import hrrq_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int PRINT_LIMIT = 40;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hrrq_cmd_if cmd_ch();
  hrrq_rsp_if rsp_ch();

  hid_report_request_queue_top dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Bench copy of the queue and timer state.
  desc_t q_store [QUEUE_DEPTH];
  int q_head;
  int q_tail;
  int q_count;
  logic q_ready;
  logic [15:0] send_tmo_cnt;
  logic retry_pend;
  logic [15:0] retry_cnt;
  logic [15:0] cfg_send_timeout;
  logic [15:0] cfg_retry_delay;

  rsp_item_t expected_results[$];
  int burst_left;
  int words_sent;
  int results_seen;
  int error_count;
  int idle_cycles;
  int timer_settings;
  int event_hist [8];
  int recoveries;

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d field %s: got %0h, expected %0h",
                                results_seen, name, got, want));
    end
  endtask

  // Advances the bench state by one command word and returns its result word.
  function automatic rsp_item_t predict_queue_step(input cmd_item_t c);
    rsp_item_t r;
    desc_t d;
    logic [8:0] total;
    r = '0;
    case (c.mode)
      MODE_QUEUE_OUT, MODE_QUEUE_SET, MODE_QUEUE_GET: begin
        total = {1'b0, c.length} +
                ((c.mode != MODE_QUEUE_GET && c.rpt_id != 8'd0) ? 9'd1 : 9'd0);
        if (q_count >= QUEUE_DEPTH) begin
          r.event_res = EV_DROP_FULL;
        end else if (c.mode != MODE_QUEUE_GET &&
                     (total > MAX_REPORT_BYTES || total > 9'd255)) begin
          r.event_res = EV_DROP_LONG;
        end else begin
          d.addr = c.usb_addr;
          d.intf = c.interface_num;
          d.rid = c.rpt_id;
          d.len = total[7:0];
          d.kind = (c.mode == MODE_QUEUE_OUT) ? KIND_OUTPUT :
                   (c.mode == MODE_QUEUE_SET) ? KIND_SET_FEATURE : KIND_GET_FEATURE;
          q_store[q_tail] = d;
          r.slot = q_tail[2:0];
          q_tail = (q_tail + 1) % QUEUE_DEPTH;
          q_count++;
          r.event_res = EV_QUEUED;
        end
      end
      MODE_POLL: begin
        if (!q_ready && send_tmo_cnt == 16'd0) begin
          q_ready = 1'b1;
          r.recovered = 1'b1;
        end
        if (q_count > 0 && q_ready) begin
          if (retry_pend && retry_cnt != 16'd0) begin
            r.event_res = EV_BACKOFF;
          end else begin
            d = q_store[q_head];
            retry_pend = 1'b0;
            r.slot = q_head[2:0];
            r.out_usb_addr = d.addr;
            r.out_interface = d.intf;
            r.out_rpt_id = d.rid;
            r.out_length = d.len;
            r.out_kind = d.kind;
            if (c.stack_accepts) begin
              q_ready = 1'b0;
              send_tmo_cnt = cfg_send_timeout;
              q_head = (q_head + 1) % QUEUE_DEPTH;
              q_count--;
              r.event_res = EV_ISSUED;
            end else begin
              // Only set and output requests back off; a refused get simply stays at the head.
              if (d.kind != KIND_GET_FEATURE) begin
                retry_pend = 1'b1;
                retry_cnt = cfg_retry_delay;
              end
              r.event_res = EV_REFUSED;
            end
          end
        end
      end
      MODE_COMPLETE: begin
        q_ready = 1'b1;
        r.event_res = EV_COMPLETED;
      end
      MODE_TICK: begin
        if (send_tmo_cnt != 16'd0) send_tmo_cnt--;
        if (retry_cnt != 16'd0) retry_cnt--;
      end
      default: begin
        r.event_res = EV_NONE;
      end
    endcase
    r.queued_count = q_count[3:0];
    r.ready_res = q_ready;
    return r;
  endfunction

  function automatic cmd_item_t make_cmd(input logic [2:0] mode, input logic [6:0] addr,
                                         input logic [7:0] intf, input logic [7:0] rid,
                                         input logic [7:0] len, input logic accepts);
    cmd_item_t c;
    c.mode = mode;
    c.usb_addr = addr;
    c.interface_num = intf;
    c.rpt_id = rid;
    c.length = len;
    c.stack_accepts = accepts;
    return c;
  endfunction

  function automatic cmd_item_t random_command();
    cmd_item_t c;
    int pick;
    int queue_pct;
    c.usb_addr = 7'($urandom_range(0, 127));
    c.interface_num = 8'($urandom_range(0, 255));
    c.rpt_id = ($urandom_range(0, 9) < 3) ? 8'd0 : 8'($urandom_range(0, 255));
    c.length = 8'($urandom_range(0, 255));
    c.stack_accepts = ($urandom_range(0, 3) != 0);
    // Fewer enqueues when the queue is nearly full, so it keeps draining and refilling.
    queue_pct = (q_count >= QUEUE_DEPTH - 2) ? 12 : 30;
    pick = $urandom_range(0, 99);
    if (pick < queue_pct) begin
      c.mode = (pick % 3 == 0) ? MODE_QUEUE_OUT :
               (pick % 3 == 1) ? MODE_QUEUE_SET : MODE_QUEUE_GET;
      if (c.mode != MODE_QUEUE_GET && $urandom_range(0, 9) != 0) begin
        c.length = 8'($urandom_range(0, MAX_REPORT_BYTES));
      end
    end else if (pick < 58) begin
      c.mode = MODE_POLL;
    end else if (pick < 70) begin
      c.mode = MODE_COMPLETE;
    end else if (pick < 96) begin
      c.mode = MODE_TICK;
    end else begin
      c.mode = 3'($urandom_range(6, 7));
    end
    return c;
  endfunction

  // Sends one word in bursts with random gaps and records its expected result.
  task automatic send_word(input cmd_item_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= w;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    expected_results.push_back(predict_queue_step(w));
    words_sent++;
  endtask

  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_timers(input logic [15:0] send_timeout, input logic [15:0] retry_delay);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= CFG_SEND_TIMEOUT;
    cfg_wdata <= send_timeout;
    @(posedge clk);
    cfg_index <= CFG_RETRY_DELAY;
    cfg_wdata <= retry_delay;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_send_timeout = send_timeout;
    cfg_retry_delay = retry_delay;
    timer_settings++;
  endtask

  task automatic test_enqueue_limits();
    send_word(make_cmd(MODE_POLL, 7'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    send_word(make_cmd(MODE_QUEUE_OUT, 7'd127, 8'd255, 8'd255, 8'd63, 1'b0));
    send_word(make_cmd(MODE_QUEUE_SET, 7'd0, 8'd0, 8'd0, 8'd64, 1'b0));
    send_word(make_cmd(MODE_QUEUE_SET, 7'd5, 8'd1, 8'd1, 8'd64, 1'b1));
    send_word(make_cmd(MODE_QUEUE_OUT, 7'd9, 8'd2, 8'd0, 8'd255, 1'b0));
    send_word(make_cmd(MODE_QUEUE_GET, 7'd127, 8'd255, 8'd255, 8'd255, 1'b1));
    send_word(make_cmd(3'd6, 7'd127, 8'd255, 8'd255, 8'd255, 1'b1));
    for (int i = 0; i < QUEUE_DEPTH - 3; i++) begin
      send_word(make_cmd(MODE_QUEUE_GET, 7'(i), 8'(i), 8'(i), 8'd16, 1'b0));
    end
    // A full queue drops the word before the length check.
    send_word(make_cmd(MODE_QUEUE_SET, 7'd1, 8'd1, 8'd7, 8'd255, 1'b0));
  endtask

  task automatic test_dispatch_cycle();
    send_word(make_cmd(MODE_POLL, 7'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    send_word(make_cmd(MODE_POLL, 7'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    repeat (2) send_word(make_cmd(MODE_TICK, 7'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    send_word(make_cmd(MODE_POLL, 7'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    send_word(make_cmd(MODE_POLL, 7'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    repeat (3) send_word(make_cmd(MODE_TICK, 7'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    send_word(make_cmd(MODE_POLL, 7'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    repeat (2) send_word(make_cmd(MODE_COMPLETE, 7'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    send_word(make_cmd(MODE_POLL, 7'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    send_word(make_cmd(MODE_POLL, 7'd0, 8'd0, 8'd0, 8'd0, 1'b1));
  endtask

  // With both registers at zero, back-off and timeout expire at once.
  task automatic test_zero_timers();
    set_timers(16'd0, 16'd0);
    send_word(make_cmd(MODE_COMPLETE, 7'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    send_word(make_cmd(MODE_POLL, 7'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    send_word(make_cmd(MODE_POLL, 7'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    send_word(make_cmd(MODE_POLL, 7'd0, 8'd0, 8'd0, 8'd0, 1'b1));
  endtask

  task automatic test_random_traffic(input logic [15:0] send_timeout,
                                     input logic [15:0] retry_delay, input int n_words);
    cmd_item_t w;
    int counted;
    counted = 0;
    set_timers(send_timeout, retry_delay);
    while (counted < n_words) begin
      w = random_command();
      send_word(w);
      if (w.mode <= MODE_TICK) begin
        counted++;
        // Let every result come back once in the middle of the phase.
        if (counted == n_words / 2) drain_results();
      end
    end
  endtask

  // The receiver draws a new stall style and stall pattern for each window of stall_bits.
  int stall_window;
  int stall_style;
  logic [31:0] stall_bits;
  always @(posedge clk) begin
    if (stall_window % 32 == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_bits = $urandom;
    end
    case (stall_style)
      0: rsp_ch.ready <= 1'b1;
      1: rsp_ch.ready <= stall_bits[stall_window % 32];
      2: rsp_ch.ready <= stall_bits[stall_window % 32] | stall_bits[(stall_window + 7) % 32];
      default: rsp_ch.ready <= stall_bits[stall_window % 32] & stall_bits[(stall_window + 7) % 32];
    endcase
    stall_window++;
  end

  always @(posedge clk) begin : check_results
    rsp_item_t want;
    rsp_item_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.data;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result word with no command pending: %h", got));
      end else begin
        want = expected_results.pop_front();
        check_field("event_res", 8'(got.event_res), 8'(want.event_res));
        check_field("slot", 8'(got.slot), 8'(want.slot));
        check_field("out_usb_addr", 8'(got.out_usb_addr), 8'(want.out_usb_addr));
        check_field("out_interface", got.out_interface, want.out_interface);
        check_field("out_rpt_id", got.out_rpt_id, want.out_rpt_id);
        check_field("out_length", got.out_length, want.out_length);
        check_field("out_kind", 8'(got.out_kind), 8'(want.out_kind));
        check_field("recovered", 8'(got.recovered), 8'(want.recovered));
        check_field("queued_count", 8'(got.queued_count), 8'(want.queued_count));
        check_field("ready_res", 8'(got.ready_res), 8'(want.ready_res));
        event_hist[want.event_res]++;
        if (want.recovered) recoveries++;
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] no word moved for %0d cycles", $realtime, IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SEND_TIMEOUT;
    cfg_wdata <= '0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.data <= '0;
    q_head = 0;
    q_tail = 0;
    q_count = 0;
    q_ready = 1'b1;
    send_tmo_cnt = '0;
    retry_pend = 1'b0;
    retry_cnt = '0;
    cfg_send_timeout = SEND_TIMEOUT_RESET;
    cfg_retry_delay = RETRY_DELAY_RESET;
    burst_left = 0;
    words_sent = 0;
    results_seen = 0;
    error_count = 0;
    idle_cycles = 0;
    timer_settings = 0;
    recoveries = 0;
    stall_window = 0;
    foreach (event_hist[i]) event_hist[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_timers(16'd3, 16'd2);
    test_enqueue_limits();
    test_dispatch_cycle();
    test_zero_timers();
    test_random_traffic(16'd1, 16'd1, 260);
    test_random_traffic(16'hFFFF, 16'hFFFF, 180);
    test_random_traffic(16'($urandom_range(2, 40)), 16'($urandom_range(2, 40)), 300);
    test_random_traffic(16'($urandom_range(2, 40)), 16'($urandom_range(2, 40)), 300);
    test_random_traffic(SEND_TIMEOUT_RESET, RETRY_DELAY_RESET, 260);

    cmd_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_results.size()));
    end

    $display("Run: %0d command words over %0d timer settings, %0d results checked.",
             words_sent, timer_settings, results_seen);
    $display("Events: queued %0d, full %0d, too long %0d, issued %0d, refused %0d,",
             event_hist[EV_QUEUED], event_hist[EV_DROP_FULL], event_hist[EV_DROP_LONG],
             event_hist[EV_ISSUED], event_hist[EV_REFUSED]);
    $display("  back-off %0d, completed %0d, recoveries %0d, mismatches %0d.",
             event_hist[EV_BACKOFF], event_hist[EV_COMPLETED], recoveries, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/hrrq_pkg.sv
design/hrrq_intf.sv
design/hrrq_desc_store.sv
design/hrrq_timers.sv
design/hrrq_core.sv
design/hid_report_request_queue_top.sv
test/hid_report_request_queue_top_tb.sv
